// ===== src/preemptive_min_key_scheduler_macros.svh =====
// Assertion macros shared by the checker of the preemptive min-key scheduler.
// Needs nothing else; included by name from the checker file.
`ifndef PREEMPTIVE_MIN_KEY_SCHEDULER_MACROS_SVH
`define PREEMPTIVE_MIN_KEY_SCHEDULER_MACROS_SVH

// A property checked at every clock edge outside reset.
`define PMKS_ASSERT_ALWAYS(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);

// A property checked in the first cycle after reset has been released.
`define PMKS_ASSERT_AFTER_RESET(label, clk, rst, prop, msg) \
   label: assert property (@(posedge clk) $past(rst) && !rst |-> prop) else $error(msg);

`endif

// ===== src/pmks_pkg.sv =====
// Types, codes and constants of the preemptive min-key scheduler.
// Depends on nothing; every file of the block but the channel interface and the macros header imports it.
`default_nettype none

package pmks_pkg;

   localparam int SLOTS_DEF   = 16;
   localparam int QUEUE_DEPTH = 2;
   localparam int QPTR_W      = $clog2(QUEUE_DEPTH);
   localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);
   localparam int CSR_IDX_W   = 1;
   localparam int CSR_DATA_W  = 5;

   // Command codes of the request channel.
   localparam logic [1:0] CMD_LOAD    = 2'd0;
   localparam logic [1:0] CMD_TICK    = 2'd1;
   localparam logic [1:0] CMD_RESTART = 2'd2;

   // Configuration register indexes.
   localparam logic [CSR_IDX_W-1:0] REG_SELECT_MODE = 1'b0;
   localparam logic [CSR_IDX_W-1:0] REG_JOB_COUNT   = 1'b1;

   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  slot;
      logic [7:0]  job_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  priority_req;
   } req_payload_type;

   typedef struct packed {
      logic [15:0] now_time;
      logic        running_valid;
      logic [3:0]  running_slot;
      logic [7:0]  running_id;
      logic        finished;
      logic [15:0] completion_time;
      logic [15:0] turnaround;
      logic [15:0] waiting;
   } rsp_payload_type;

   typedef struct packed {
      logic [CSR_IDX_W-1:0]  reg_index;
      logic [CSR_DATA_W-1:0] reg_data;
   } csr_payload_type;

   typedef struct packed {
      logic       select_mode;
      logic [4:0] job_count;
   } cfg_type;

   // One classified command as it waits in the queue.
   typedef struct packed {
      logic [1:0]  cmd;
      logic [3:0]  slot;
      logic [7:0]  job_id;
      logic [15:0] arrival;
      logic [15:0] burst;
      logic [7:0]  prio_value;
   } job_cmd_type;

   // One job slot as held in the slot memory.
   typedef struct packed {
      logic [7:0]  job_id;
      logic [15:0] arrival;
      logic [15:0] remaining;
      logic [15:0] burst;
      logic [7:0]  prio_value;
   } slot_entry_type;

endpackage

`default_nettype wire

// ===== src/pmks_chan_if.sv =====
// Valid/ready channel carrying one payload of a chosen type.
// Uses no package; the payload type is given where the channel is declared.
`default_nettype none

interface pmks_chan_if #(parameter type payload_type = logic);

   logic        valid;
   logic        ready;
   payload_type payload;

   modport source (output valid, output payload, input ready);
   modport sink (input valid, input payload, output ready);

endinterface

`default_nettype wire

// ===== src/pmks_front.sv =====
// Front end: takes request transactions, drops those that change nothing
// and hands the rest to the command queue. Uses pmks_pkg and pmks_chan_if.
`default_nettype none

module pmks_front #(
   parameter int SLOTS = pmks_pkg::SLOTS_DEF
) (
   pmks_chan_if.sink          req_ch,
   input  logic               q_full,
   output logic               q_push,
   output pmks_pkg::job_cmd_type q_data
);
   import pmks_pkg::*;

   logic slot_ok;
   logic keep;

   // A load into a slot beyond the configured storage is discarded.
   assign slot_ok = int'(req_ch.payload.slot) < SLOTS;

   always_comb begin
      keep = 1'b0;
      case (req_ch.payload.cmd)
         CMD_LOAD:    keep = slot_ok;
         CMD_TICK:    keep = 1'b1;
         CMD_RESTART: keep = 1'b1;
         default:     keep = 1'b0;
      endcase
   end

   assign req_ch.ready = !q_full;
   assign q_push       = req_ch.valid && !q_full && keep;

   assign q_data.cmd        = req_ch.payload.cmd;
   assign q_data.slot       = req_ch.payload.slot;
   assign q_data.job_id     = req_ch.payload.job_id;
   assign q_data.arrival    = req_ch.payload.arrival;
   assign q_data.burst      = req_ch.payload.burst;
   assign q_data.prio_value = req_ch.payload.priority_req;

endmodule

`default_nettype wire

// ===== src/pmks_fifo.sv =====
// Short command queue between the front end and the back end.
// Uses pmks_pkg for the entry type and the queue depth.
`default_nettype none

module pmks_fifo (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  push,
   input  pmks_pkg::job_cmd_type push_data,
   output logic                  full,
   input  logic                  pop,
   output logic                  pop_valid,
   output pmks_pkg::job_cmd_type pop_data
);
   import pmks_pkg::*;

   job_cmd_type         entry_ff [QUEUE_DEPTH];
   logic [QPTR_W-1:0]   wr_ptr_ff, wr_ptr_in;
   logic [QPTR_W-1:0]   rd_ptr_ff, rd_ptr_in;
   logic [QCNT_W-1:0]   count_ff, count_in;
   logic                do_push, do_pop;

   assign full      = count_ff == QCNT_W'(QUEUE_DEPTH);
   assign pop_valid = count_ff != '0;
   assign pop_data  = entry_ff[rd_ptr_ff];

   assign do_push = push && !full;
   assign do_pop  = pop && pop_valid;

   // The depth is a power of two, so the pointers wrap by themselves.
   always_comb begin
      wr_ptr_in = do_push ? wr_ptr_ff + QPTR_W'(1) : wr_ptr_ff;
      rd_ptr_in = do_pop ? rd_ptr_ff + QPTR_W'(1) : rd_ptr_ff;
      count_in  = count_ff;
      if (do_push && !do_pop) begin
         count_in = count_ff + QCNT_W'(1);
      end else if (do_pop && !do_push) begin
         count_in = count_ff - QCNT_W'(1);
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (do_push) begin
         entry_ff[wr_ptr_ff] <= push_data;
      end
   end

endmodule

`default_nettype wire

// ===== src/pmks_back.sv =====
// Back end: slot memory, time counter, one-slot-per-cycle selection scan
// and the result register. Uses pmks_pkg and pmks_chan_if.
`default_nettype none

module pmks_back #(
   parameter int SLOTS = pmks_pkg::SLOTS_DEF
) (
   input  logic                  clock,
   input  logic                  reset,
   input  pmks_pkg::cfg_type     cfg,
   input  logic                  q_valid,
   input  pmks_pkg::job_cmd_type q_data,
   output logic                  q_pop,
   pmks_chan_if.source           rsp_ch
);
   import pmks_pkg::*;

   localparam int IDX_W = $clog2(SLOTS);
   localparam int CNT_W = $clog2(SLOTS + 1);

   localparam logic [1:0] ST_IDLE   = 2'd0;
   localparam logic [1:0] ST_SCAN   = 2'd1;
   localparam logic [1:0] ST_FINISH = 2'd2;
   localparam logic [1:0] ST_REPORT = 2'd3;

   logic [1:0]       state_ff, state_in;
   slot_entry_type   mem [SLOTS];
   slot_entry_type   rd_data_ff;
   slot_entry_type   best_ff, best_in;
   slot_entry_type   wr_data;
   logic [IDX_W-1:0] rd_addr, wr_addr;
   logic [IDX_W-1:0] rd_slot_ff, rd_slot_in;
   logic [IDX_W-1:0] best_slot_ff, best_slot_in;
   logic             wr_en;
   logic             rd_valid_ff, rd_valid_in;
   logic             found_ff, found_in;
   logic [CNT_W-1:0] idx_ff, idx_in;
   logic [CNT_W-1:0] limit;
   logic [15:0]      tick_ff, tick_in;
   logic [15:0]      now_ff, now_in;
   logic [15:0]      ct;
   logic [15:0]      ct_ff, ct_in;
   logic [15:0]      ta_ff, ta_in;
   logic             fin_ff, fin_in;
   logic [15:0]      key_cand, key_best;
   logic             eligible, beats, last_read;
   logic [15:0]      waiting;
   logic             rsp_valid_ff, rsp_valid_in;
   rsp_payload_type  rsp_ff, rsp_in;

   // A job count beyond the storage acts as the full storage.
   assign limit = (int'(cfg.job_count) < SLOTS) ? CNT_W'(cfg.job_count) : CNT_W'(SLOTS);

   assign rd_addr   = idx_ff[IDX_W-1:0];
   assign last_read = rd_valid_ff && (CNT_W'(rd_slot_ff) == limit - CNT_W'(1));

   assign key_cand = cfg.select_mode ? {8'd0, rd_data_ff.prio_value} : rd_data_ff.remaining;
   assign key_best = cfg.select_mode ? {8'd0, best_ff.prio_value} : best_ff.remaining;
   assign eligible = (rd_data_ff.remaining != 16'd0) && (rd_data_ff.arrival <= tick_ff);
   // Slots are read in ascending order, so a full tie keeps the earlier slot.
   assign beats    = !found_ff || (key_cand < key_best) ||
                     ((key_cand == key_best) && (rd_data_ff.arrival < best_ff.arrival));

   assign ct      = (tick_ff == 16'hFFFF) ? tick_ff : tick_ff + 16'd1;
   assign waiting = (ta_ff >= best_ff.burst) ? ta_ff - best_ff.burst : 16'd0;

   always_comb begin
      state_in     = state_ff;
      best_in      = best_ff;
      best_slot_in = best_slot_ff;
      found_in     = found_ff;
      idx_in       = idx_ff;
      rd_valid_in  = 1'b0;
      rd_slot_in   = rd_slot_ff;
      tick_in      = tick_ff;
      now_in       = now_ff;
      ct_in        = ct_ff;
      ta_in        = ta_ff;
      fin_in       = fin_ff;
      q_pop        = 1'b0;
      wr_en        = 1'b0;
      wr_addr      = best_slot_ff;
      wr_data      = best_ff;
      wr_data.remaining = best_ff.remaining - 16'd1;
      rsp_valid_in = rsp_valid_ff && !rsp_ch.ready;
      rsp_in       = rsp_ff;

      case (state_ff)
         ST_IDLE: begin
            if (q_valid) begin
               q_pop = 1'b1;
               case (q_data.cmd)
                  CMD_LOAD: begin
                     wr_en              = 1'b1;
                     wr_addr            = IDX_W'(q_data.slot);
                     wr_data.job_id     = q_data.job_id;
                     wr_data.arrival    = q_data.arrival;
                     wr_data.remaining  = q_data.burst;
                     wr_data.burst      = q_data.burst;
                     wr_data.prio_value = q_data.prio_value;
                  end
                  CMD_RESTART: begin
                     tick_in = 16'd0;
                  end
                  CMD_TICK: begin
                     found_in = 1'b0;
                     idx_in   = '0;
                     state_in = (limit == '0) ? ST_FINISH : ST_SCAN;
                  end
                  default: begin
                  end
               endcase
            end
         end
         ST_SCAN: begin
            if (idx_ff < limit) begin
               rd_valid_in = 1'b1;
               rd_slot_in  = rd_addr;
               idx_in      = idx_ff + CNT_W'(1);
            end
            if (rd_valid_ff && eligible && beats) begin
               best_in      = rd_data_ff;
               best_slot_in = rd_slot_ff;
               found_in     = 1'b1;
            end
            if (last_read) begin
               state_in = ST_FINISH;
            end
         end
         ST_FINISH: begin
            now_in  = tick_ff;
            ct_in   = ct;
            fin_in  = found_ff && (best_ff.remaining == 16'd1);
            ta_in   = (ct >= best_ff.arrival) ? ct - best_ff.arrival : 16'd0;
            wr_en   = found_ff;
            tick_in = ct;
            state_in = ST_REPORT;
         end
         ST_REPORT: begin
            if (!rsp_valid_ff || rsp_ch.ready) begin
               rsp_valid_in           = 1'b1;
               rsp_in.now_time        = now_ff;
               rsp_in.running_valid   = found_ff;
               rsp_in.running_slot    = found_ff ? 4'(best_slot_ff) : 4'd0;
               rsp_in.running_id      = found_ff ? best_ff.job_id : 8'd0;
               rsp_in.finished        = fin_ff;
               rsp_in.completion_time = fin_ff ? ct_ff : 16'd0;
               rsp_in.turnaround      = fin_ff ? ta_ff : 16'd0;
               rsp_in.waiting         = fin_ff ? waiting : 16'd0;
               state_in               = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rd_valid_ff  <= 1'b0;
         found_ff     <= 1'b0;
         idx_ff       <= '0;
         tick_ff      <= 16'd0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rd_valid_ff  <= rd_valid_in;
         found_ff     <= found_in;
         idx_ff       <= idx_in;
         tick_ff      <= tick_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      best_ff      <= best_in;
      best_slot_ff <= best_slot_in;
      rd_slot_ff   <= rd_slot_in;
      now_ff       <= now_in;
      ct_ff        <= ct_in;
      ta_ff        <= ta_in;
      fin_ff       <= fin_in;
      rsp_ff       <= rsp_in;
   end

   // Slot memory: one write port, one registered read port.
   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rsp_ch.valid   = rsp_valid_ff;
   assign rsp_ch.payload = rsp_ff;

endmodule

`default_nettype wire

// ===== src/preemptive_min_key_scheduler.sv =====
// A tick transaction's result is presented once the back end has scanned the first limit
// slots, limit being the job count capped at SLOTS, and registered the outcome, if the back end is free.
// Load and restart transactions give no result and occupy the back end for one cycle;
// unknown commands are dropped by the front end.
// The back end takes no new command until a tick's scan is through, and the scan reads one
// slot per cycle. Reset clears the configuration, time, queue and result register only.
`default_nettype none

module preemptive_min_key_scheduler #(
   parameter int SLOTS = pmks_pkg::SLOTS_DEF
) (
   input logic         clock,
   input logic         reset,
   pmks_chan_if.sink   req_ch,
   pmks_chan_if.source rsp_ch,
   pmks_chan_if.sink   csr_ch
);
   import pmks_pkg::*;

   // Configuration registers. The user is to write them only while the block is idle;
   // the block does not enforce this. Writes are always accepted and take effect at once.
   logic       select_mode_ff;
   logic [4:0] job_count_ff;
   cfg_type    cfg;

   // Queue between the front end and the back end.
   logic        q_push;
   logic        q_full;
   logic        q_pop;
   logic        q_valid;
   job_cmd_type q_push_data;
   job_cmd_type q_pop_data;

   assign csr_ch.ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         select_mode_ff <= 1'b0;
         job_count_ff   <= 5'd0;
      end else if (csr_ch.valid) begin
         case (csr_ch.payload.reg_index)
            REG_SELECT_MODE: select_mode_ff <= csr_ch.payload.reg_data[0];
            REG_JOB_COUNT:   job_count_ff   <= csr_ch.payload.reg_data;
            default: begin
            end
         endcase
      end
   end

   assign cfg.select_mode = select_mode_ff;
   assign cfg.job_count   = job_count_ff;

   // The front end classifies each request transaction and queues the ones
   // that change state. It keeps taking transactions while the back end is
   // still scanning, until the queue fills.
   pmks_front #(
      .SLOTS (SLOTS)
   ) u_front (
      .req_ch (req_ch),
      .q_full (q_full),
      .q_push (q_push),
      .q_data (q_push_data)
   );

   pmks_fifo u_fifo (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_push_data),
      .full      (q_full),
      .pop       (q_pop),
      .pop_valid (q_valid),
      .pop_data  (q_pop_data)
   );

   // The back end runs one command at a time: a load writes one slot, a
   // restart clears time, and a tick reads the active slots one per cycle,
   // keeps the best candidate, charges it one tick and reports the outcome
   // through a result register that the next command may overlap.
   pmks_back #(
      .SLOTS (SLOTS)
   ) u_back (
      .clock   (clock),
      .reset   (reset),
      .cfg     (cfg),
      .q_valid (q_valid),
      .q_data  (q_pop_data),
      .q_pop   (q_pop),
      .rsp_ch  (rsp_ch)
   );

endmodule

`default_nettype wire

// ===== src/pmks_checker.sv =====
// Port-level checker of the preemptive min-key scheduler, bound to the top level.
// Uses pmks_pkg and the assertion macros header.
`default_nettype none
`include "preemptive_min_key_scheduler_macros.svh"

module pmks_checker (
   input logic                      clock,
   input logic                      reset,
   input logic                      rsp_valid,
   input logic                      rsp_ready,
   input pmks_pkg::rsp_payload_type rsp_payload,
   input logic                      csr_ready
);
   import pmks_pkg::*;

   `PMKS_ASSERT_ALWAYS(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready |=> rsp_valid && $stable(rsp_payload), "result changed while stalled")
   `PMKS_ASSERT_ALWAYS(a_idle_zero, clock, reset, rsp_valid && !rsp_payload.running_valid |-> !rsp_payload.finished && rsp_payload.running_slot == 4'd0 && rsp_payload.running_id == 8'd0 && rsp_payload.completion_time == 16'd0, "idle tick carries job data")
   `PMKS_ASSERT_ALWAYS(a_finish_times, clock, reset, rsp_valid && rsp_payload.finished |-> rsp_payload.running_valid && rsp_payload.completion_time != 16'd0 && rsp_payload.turnaround <= rsp_payload.completion_time && rsp_payload.waiting <= rsp_payload.turnaround, "inconsistent completion times")
   `PMKS_ASSERT_ALWAYS(a_unfinished_zero, clock, reset, rsp_valid && !rsp_payload.finished |-> rsp_payload.completion_time == 16'd0 && rsp_payload.turnaround == 16'd0 && rsp_payload.waiting == 16'd0, "times reported for an unfinished job")
   `PMKS_ASSERT_AFTER_RESET(a_reset_state, clock, reset, !rsp_valid && csr_ready, "wrong channel state after reset")

endmodule

bind preemptive_min_key_scheduler pmks_checker u_pmks_checker (
   .clock       (clock),
   .reset       (reset),
   .rsp_valid   (rsp_ch.valid),
   .rsp_ready   (rsp_ch.ready),
   .rsp_payload (rsp_ch.payload),
   .csr_ready   (csr_ch.ready)
);

`default_nettype wire

// ===== verif/tb_preemptive_min_key_scheduler.sv =====
// Self-checking testbench for the preemptive min-key job scheduler.
// Depends on pmks_pkg, pmks_chan_if and the scheduler RTL; it reads no files.
`timescale 1ns / 1ps

module tb_preemptive_min_key_scheduler;

   import pmks_pkg::*;

   // The request channel also carries a fourth command code, which the block must ignore.
   localparam logic [1:0] CMD_UNKNOWN = 2'd3;

   localparam int SLOT_COUNT    = SLOTS_DEF;
   localparam int RANDOM_ITEMS  = 1650;
   // A tick occupies the back end for a scan of at most SLOTS slots, and this wait lets
   // a quiet block settle.
   localparam int SETTLE_CYCLES = 32;

   // One line of the directed plan: a request, or a register write when is_csr is set.
   // When typed is set, the expected result is written into the table by hand.
   typedef struct packed {
      logic            is_csr;
      logic            csr_index;
      logic [4:0]      csr_value;
      req_payload_type req;
      logic            typed;
      rsp_payload_type exp;
   } plan_row_type;

   localparam req_payload_type TICK_REQ  = '{cmd: CMD_TICK, default: '0};
   localparam req_payload_type NO_REQ    = '0;
   localparam rsp_payload_type NO_RSP    = '0;
   localparam rsp_payload_type IDLE_AT_0 = '{now_time: 16'd0, default: '0};
   localparam rsp_payload_type IDLE_AT_1 = '{now_time: 16'd1, default: '0};
   // Slot 0 (burst 2, arrived at 0) completes at tick 0 after a restart: its waiting
   // time would be negative and is floored at zero.
   localparam rsp_payload_type SLOT0_DONE_AT_0 = '{
      now_time: 16'd0, running_valid: 1'b1, running_slot: 4'd0, running_id: 8'hFF,
      finished: 1'b1, completion_time: 16'd1, turnaround: 16'd1, waiting: 16'd0};

   localparam plan_row_type DIRECTED_PLAN [0:25] = '{
      // Idle tick straight after reset, with no slots taking part.
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b1, IDLE_AT_0},
      // Unknown command with every payload bit set: no result, no change.
      '{1'b0, 1'b0, 5'd0, '{CMD_UNKNOWN, 4'hF, 8'hFF, 16'hFFFF, 16'hFFFF, 8'hFF}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd0, 8'hFF, 16'd0, 16'd2, 8'hFF}, 1'b0, NO_RSP},
      // Zero burst: the job is loaded but never runs.
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd1, 8'h00, 16'd0, 16'd0, 8'h00}, 1'b0, NO_RSP},
      // Largest arrival and burst: the job is not ready for a long time.
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd2, 8'h5A, 16'hFFFF, 16'hFFFF, 8'h80}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd3, 8'h11, 16'd1, 16'd1, 8'h00}, 1'b0, NO_RSP},
      '{1'b1, REG_JOB_COUNT, 5'd4, NO_REQ, 1'b0, NO_RSP},
      // The shorter job in slot 3 runs first and completes.
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, '{CMD_RESTART, 4'hA, 8'h55, 16'hAAAA, 16'h5555, 8'hAA}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b1, SLOT0_DONE_AT_0},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b1, IDLE_AT_1},
      // Priority mode: equal priority and arrival, so the lower slot wins.
      '{1'b1, REG_SELECT_MODE, 5'd1, NO_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd0, 8'h21, 16'd0, 16'd3, 8'h05}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd1, 8'h22, 16'd0, 16'd1, 8'h05}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      // Same priority but a later arrival: it loses the tie.
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd3, 8'h23, 16'd1, 16'd2, 8'h05}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      // A more urgent job preempts the one waiting.
      '{1'b0, 1'b0, 5'd0, '{CMD_LOAD, 4'd2, 8'hA5, 16'd0, 16'd4, 8'h00}, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      // Back to least remaining time: slot 3 now has less to do than slot 2.
      '{1'b1, REG_SELECT_MODE, 5'd0, NO_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP},
      '{1'b0, 1'b0, 5'd0, TICK_REQ, 1'b0, NO_RSP}
   };

   logic clock = 1'b0;
   logic reset = 1'b1;

   pmks_chan_if #(.payload_type(req_payload_type)) req_ch ();
   pmks_chan_if #(.payload_type(rsp_payload_type)) rsp_ch ();
   pmks_chan_if #(.payload_type(csr_payload_type)) csr_ch ();

   preemptive_min_key_scheduler #(
      .SLOTS(SLOT_COUNT)
   ) i_dut (
      .clock  (clock),
      .reset  (reset),
      .req_ch (req_ch),
      .rsp_ch (rsp_ch),
      .csr_ch (csr_ch)
   );

   always #6 clock = ~clock;

   // Our own copy of the scheduler: slot table, time and the two registers.
   slot_entry_type  job_table [SLOT_COUNT];
   logic [15:0]     sched_tick;
   logic            sel_mode;
   logic [4:0]      job_count_reg;

   // Schedule results still owed by the block, oldest first.
   rsp_payload_type expected_ticks [$];

   // When calm is set, neither side inserts idle cycles.
   bit calm;

   int mismatch_count;
   int requests_sent;
   int results_checked;
   int completions_seen;
   int idle_ticks_seen;

   // True when slot a should be chosen over slot b under the current mode.
   function automatic bit key_wins(int a, int b);
      logic [15:0] key_a;
      logic [15:0] key_b;
      key_a = sel_mode ? {8'd0, job_table[a].prio_value} : job_table[a].remaining;
      key_b = sel_mode ? {8'd0, job_table[b].prio_value} : job_table[b].remaining;
      if (key_a != key_b)
         return key_a < key_b;
      if (job_table[a].arrival != job_table[b].arrival)
         return job_table[a].arrival < job_table[b].arrival;
      return a < b;
   endfunction

   // Applies one accepted request to the copy of the scheduler. Returns 1 when the
   // request owes a result, which is then left in tick_rsp.
   function automatic bit schedule_request(input req_payload_type p,
                                           output rsp_payload_type tick_rsp);
      int          limit;
      int          best;
      bit          found;
      logic [16:0] done_at;
      logic [15:0] turn;
      tick_rsp = '0;
      found    = 1'b0;
      best     = 0;
      case (p.cmd)
         CMD_LOAD: begin
            job_table[p.slot] = '{p.job_id, p.arrival, p.burst, p.burst, p.priority_req};
            return 1'b0;
         end
         CMD_RESTART: begin
            sched_tick = '0;
            return 1'b0;
         end
         CMD_TICK: begin
            limit = (job_count_reg < SLOT_COUNT) ? int'(job_count_reg) : SLOT_COUNT;
            tick_rsp.now_time = sched_tick;
            for (int j = 0; j < limit; j++) begin
               if (job_table[j].remaining != 0 && job_table[j].arrival <= sched_tick) begin
                  if (!found || key_wins(j, best)) begin
                     best  = j;
                     found = 1'b1;
                  end
               end
            end
            if (found) begin
               tick_rsp.running_valid = 1'b1;
               tick_rsp.running_slot  = best[3:0];
               tick_rsp.running_id    = job_table[best].job_id;
               job_table[best].remaining = job_table[best].remaining - 16'd1;
               if (job_table[best].remaining == 0) begin
                  done_at = {1'b0, sched_tick} + 17'd1;
                  if (done_at > 17'h0FFFF)
                     done_at = 17'h0FFFF;
                  turn = (done_at[15:0] >= job_table[best].arrival) ?
                         done_at[15:0] - job_table[best].arrival : 16'd0;
                  tick_rsp.finished        = 1'b1;
                  tick_rsp.completion_time = done_at[15:0];
                  tick_rsp.turnaround      = turn;
                  tick_rsp.waiting         = (turn >= job_table[best].burst) ?
                                             turn - job_table[best].burst : 16'd0;
               end
            end
            if (sched_tick != 16'hFFFF)
               sched_tick = sched_tick + 16'd1;
            return 1'b1;
         end
         default: return 1'b0;
      endcase
   endfunction

   function automatic int draw_gap();
      return calm ? 0 : $urandom_range(0, 8);
   endfunction

   // Sends one request transaction and books its expected result. A row of the directed
   // plan may give the expected result by hand; the copy of the scheduler still advances.
   task automatic push_req(input req_payload_type p, input bit typed,
                           input rsp_payload_type typed_rsp);
      int              gap;
      rsp_payload_type predicted;
      gap = draw_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid   <= 1'b1;
      req_ch.payload <= p;
      do @(posedge clock); while (!req_ch.ready);
      requests_sent++;
      if (schedule_request(p, predicted))
         expected_ticks.insert(expected_ticks.size(), typed ? typed_rsp : predicted);
   endtask

   // Holds the request channel quiet until every owed result is in, then a little longer
   // so that a load or restart still in the back end has finished too.
   task automatic drain_results(input int settle);
      req_ch.valid <= 1'b0;
      while (expected_ticks.size() != 0)
         @(posedge clock);
      repeat (settle + 1) @(posedge clock);
   endtask

   task automatic write_csr(input logic [CSR_IDX_W-1:0] index,
                            input logic [CSR_DATA_W-1:0] value);
      drain_results(SETTLE_CYCLES);
      csr_ch.valid   <= 1'b1;
      csr_ch.payload <= '{reg_index: index, reg_data: value};
      do @(posedge clock); while (!csr_ch.ready);
      csr_ch.valid <= 1'b0;
      if (index == REG_SELECT_MODE)
         sel_mode = value[0];
      else
         job_count_reg = value;
   endtask

   // A load with content that is mostly plausible: arrivals close to the present, short
   // bursts and a narrow band of priorities so that ties happen. Now and then a field
   // takes any value it can hold.
   function automatic req_payload_type random_load(input int target_slot);
      req_payload_type p;
      logic [16:0]     soon;
      p.cmd    = CMD_LOAD;
      p.slot   = target_slot[3:0];
      p.job_id = 8'($urandom_range(0, 255));
      soon     = {1'b0, sched_tick} + 17'($urandom_range(0, 12));
      case ($urandom_range(0, 9))
         0:       p.arrival = 16'($urandom_range(0, 16'hFFFF));
         1:       p.arrival = '0;
         default: p.arrival = soon[16] ? 16'hFFFF : soon[15:0];
      endcase
      case ($urandom_range(0, 9))
         0:       p.burst = '0;
         1:       p.burst = 16'($urandom_range(0, 16'hFFFF));
         2:       p.burst = 16'($urandom_range(20, 200));
         default: p.burst = 16'($urandom_range(1, 12));
      endcase
      p.priority_req = $urandom_range(0, 1) ? 8'($urandom_range(0, 3)) :
                                              8'($urandom_range(0, 255));
      return p;
   endfunction

   // A non-load command whose other fields are noise the block must not look at.
   function automatic req_payload_type noisy_command(input logic [1:0] code);
      req_payload_type p;
      p.cmd          = code;
      p.slot         = 4'($urandom_range(0, 15));
      p.job_id       = 8'($urandom_range(0, 255));
      p.arrival      = 16'($urandom_range(0, 16'hFFFF));
      p.burst        = 16'($urandom_range(0, 16'hFFFF));
      p.priority_req = 8'($urandom_range(0, 255));
      return p;
   endfunction

   task automatic check_field(input string name, input logic [15:0] want,
                              input logic [15:0] got);
      if (got !== want) begin
         $error("%s: expected %0h, got %0h", name, want, got);
         mismatch_count++;
      end
   endtask

   // Result side: every accepted result is held against the oldest expectation.
   always @(posedge clock) begin : result_check
      rsp_payload_type want;
      rsp_payload_type got;
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         got = rsp_ch.payload;
         if (expected_ticks.size() == 0) begin
            $error("unexpected result transaction at now_time %0h", got.now_time);
            mismatch_count++;
         end else begin
            want = expected_ticks[0];
            expected_ticks.delete(0);
            check_field("now_time", want.now_time, got.now_time);
            check_field("running_valid", want.running_valid, got.running_valid);
            check_field("running_slot", want.running_slot, got.running_slot);
            check_field("running_id", want.running_id, got.running_id);
            check_field("finished", want.finished, got.finished);
            check_field("completion_time", want.completion_time, got.completion_time);
            check_field("turnaround", want.turnaround, got.turnaround);
            check_field("waiting", want.waiting, got.waiting);
            results_checked++;
            if (want.finished)
               completions_seen++;
            if (!want.running_valid)
               idle_ticks_seen++;
         end
      end
   end

   // Result side handshake: after each transaction the receiver may hold ready low for a
   // random gap, so that back-pressure reaches the back end, the queue and the request channel.
   initial begin : result_sink
      int stall;
      forever begin
         stall = draw_gap();
         if (stall > 0) begin
            rsp_ch.ready <= 1'b0;
            repeat (stall) @(posedge clock);
         end
         rsp_ch.ready <= 1'b1;
         do @(posedge clock); while (!(rsp_ch.valid && rsp_ch.ready));
      end
   end

   // Main sequence: reset, the directed plan, a full load of every slot, then random
   // phases under changing settings.
   initial begin : stimulus
      int              random_count;
      int              phase_items;
      int              limit;
      int              pick;
      logic [4:0]      count_value;
      req_payload_type p;

      req_ch.valid   <= 1'b0;
      req_ch.payload <= '0;
      csr_ch.valid   <= 1'b0;
      csr_ch.payload <= '0;
      calm            = 1'b0;
      mismatch_count  = 0;
      random_count    = 0;
      sched_tick      = '0;
      sel_mode        = 1'b0;
      job_count_reg   = '0;
      foreach (job_table[s])
         job_table[s] = '0;

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      foreach (DIRECTED_PLAN[i]) begin
         if (DIRECTED_PLAN[i].is_csr)
            write_csr(DIRECTED_PLAN[i].csr_index, DIRECTED_PLAN[i].csr_value);
         else
            push_req(DIRECTED_PLAN[i].req, DIRECTED_PLAN[i].typed, DIRECTED_PLAN[i].exp);
      end

      // Every slot is loaded here, so that any job count from now on only ever reads
      // slots that hold a job.
      for (int s = 0; s < SLOT_COUNT; s++) begin
         push_req(random_load(s), 1'b0, NO_RSP);
         random_count++;
      end

      while (random_count < RANDOM_ITEMS) begin
         calm = ($urandom_range(0, 4) == 0);
         write_csr(REG_SELECT_MODE, CSR_DATA_W'($urandom_range(0, 1)));
         case ($urandom_range(0, 6))
            0:       count_value = 5'd0;
            1:       count_value = 5'd16;
            2:       count_value = 5'd31;
            3:       count_value = 5'($urandom_range(17, 30));
            default: count_value = 5'($urandom_range(1, 15));
         endcase
         write_csr(REG_JOB_COUNT, count_value);
         limit = (count_value < SLOT_COUNT) ? int'(count_value) : SLOT_COUNT;

         // Most phases open with a restart and a fresh set of jobs in the active slots.
         if ($urandom_range(0, 3) != 0) begin
            push_req(noisy_command(CMD_RESTART), 1'b0, NO_RSP);
            random_count++;
            for (int s = 0; s < limit; s++) begin
               if ($urandom_range(0, 2) != 0) begin
                  push_req(random_load(s), 1'b0, NO_RSP);
                  random_count++;
               end
            end
         end

         phase_items = $urandom_range(30, 90);
         for (int n = 0; n < phase_items; n++) begin
            // Occasionally the sender waits until the block has nothing left to deliver.
            if ($urandom_range(0, 59) == 0)
               drain_results(0);
            pick = $urandom_range(0, 99);
            if (pick < 3) begin
               push_req(noisy_command(CMD_UNKNOWN), 1'b0, NO_RSP);
            end else begin
               if (pick < 8)
                  p = noisy_command(CMD_RESTART);
               else if (pick < 30)
                  p = random_load((limit > 0 && $urandom_range(0, 3) != 0) ?
                                  $urandom_range(0, limit - 1) : $urandom_range(0, 15));
               else
                  p = noisy_command(CMD_TICK);
               push_req(p, 1'b0, NO_RSP);
               random_count++;
            end
         end
      end

      drain_results(SETTLE_CYCLES);
      $display("Run covered %0d request transactions under both modes and many job counts,",
               requests_sent);
      $display("with %0d results checked: %0d completions and %0d idle ticks.",
               results_checked, completions_seen, idle_ticks_seen);
      if (mismatch_count == 0)
         $display("tb_preemptive_min_key_scheduler: done, clean");
      else
         $display("tb_preemptive_min_key_scheduler: done, errors");
      $finish;
   end

   // Watchdog: far beyond the slowest correct run under the longest idling on both sides.
   initial begin : watchdog
      #20_000_000;
      $display("tb_preemptive_min_key_scheduler: done, errors");
      $finish;
   end

endmodule

// ===== sim.f =====
+incdir+src
src/pmks_pkg.sv
src/pmks_chan_if.sv
src/pmks_front.sv
src/pmks_fifo.sv
src/pmks_back.sv
src/preemptive_min_key_scheduler.sv
src/pmks_checker.sv
verif/tb_preemptive_min_key_scheduler.sv
